FILE: rtl/sprite_pixel_collision_core_defines.svh
// assertion macros used by sprite_pixel_collision_core
`ifndef SPRITE_PIXEL_COLLISION_CORE_DEFINES_SVH
`define SPRITE_PIXEL_COLLISION_CORE_DEFINES_SVH

`ifndef SYNTH
`define SPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPC_ASSERT_IMPL(lbl, ante, cons, msg)
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/spc_pkg.sv
`timescale 1ns / 1ps
package spc_pkg;

  localparam int unsigned SPC_MAX_WIDTH  = 64;
  localparam int unsigned SPC_MAX_HEIGHT = 64;
  localparam int unsigned SPC_LANES      = 4;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned DIM_W       = 7;
  localparam int unsigned ROW_IDX_W   = 6;
  localparam int unsigned ROW_BITS_W  = 64;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_A = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_SPRITE = 2'd2,
    MODE_POINT  = 2'd3
  } spc_mode_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_A_LEFT   = 3'd0,
    CFG_A_TOP    = 3'd1,
    CFG_A_WIDTH  = 3'd2,
    CFG_A_HEIGHT = 3'd3,
    CFG_B_LEFT   = 3'd4,
    CFG_B_TOP    = 3'd5,
    CFG_B_WIDTH  = 3'd6,
    CFG_B_HEIGHT = 3'd7
  } spc_cfg_e;

endpackage

FILE: rtl/spc_mask_mem.sv
`timescale 1ns / 1ps
module spc_mask_mem #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ROW_W-1:0]     waddr_i,
  input  logic [MAX_WIDTH-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [ROW_W-1:0]     raddr_i,
  output logic [MAX_WIDTH-1:0] rdata_o
);

  logic [MAX_WIDTH-1:0] mem_q [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/spc_lane.sv
`timescale 1ns / 1ps
module spc_lane #(
  parameter int unsigned MAX_WIDTH = 64,
  parameter int unsigned LANES     = 4,
  parameter int unsigned LANE_IDX  = 0,
  localparam int unsigned OFS_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned LEN_W = $clog2(MAX_WIDTH + 1)
) (
  input  logic                 clk_i,
  input  logic [MAX_WIDTH-1:0] va_i,
  input  logic [MAX_WIDTH-1:0] vb_i,
  input  logic [OFS_W-1:0]     sa_i,
  input  logic [OFS_W-1:0]     sb_i,
  input  logic [LEN_W-1:0]     len_i,
  output logic                 hit_o
);

  localparam int unsigned LW = (MAX_WIDTH + LANES - 1) / LANES;
  localparam int unsigned PW = LANES * LW;

  logic [PW-1:0] ash;
  logic [PW-1:0] bsh;
  logic [LW-1:0] span;
  logic          hit_d;
  logic          hit_q;

  // each lane checks its own slice of the aligned column window
  always_comb begin
    ash = PW'(va_i) >> sa_i;
    bsh = PW'(vb_i) >> sb_i;
    for (int j = 0; j < LW; j++) begin
      span[j] = 32'(len_i) > 32'(LANE_IDX * LW + j);
    end
    hit_d = |(ash[LANE_IDX*LW +: LW] & bsh[LANE_IDX*LW +: LW] & span);
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  assign hit_o = hit_q;

endmodule

FILE: rtl/spc_merge.sv
`timescale 1ns / 1ps
module spc_merge #(
  parameter int unsigned LANES = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             vld_i,
  input  logic [LANES-1:0] lane_hit_i,
  output logic             hit_o
);

  logic hit_d;
  logic hit_q;

  // sticky or over all lanes and all swept rows
  always_comb begin
    if (clr_i) begin
      hit_d = 1'b0;
    end else begin
      hit_d = hit_q | (vld_i & (|lane_hit_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

FILE: rtl/sprite_pixel_collision_core.sv
// row loads: accepted one per cycle while no test is in flight, no result
// point test: ST_BOX, ST_ISECT, ST_PREAD, ST_PWAIT, ST_RESULT; misses skip the read
// sprite test: ST_BOX, ST_ISECT, then ST_RESULT if the boxes miss, else ST_SETUP, ST_ROWS
//   (one row pair per cycle from the mask memory read ports), ST_DRAIN, ST_RESULT
// one test in flight at a time; the output register frees the input while a result waits
// reset restores the box registers, the opacity masks hold nothing until rows are loaded
`timescale 1ns / 1ps
`include "sprite_pixel_collision_core_defines.svh"
module sprite_pixel_collision_core
  import spc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = SPC_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = SPC_MAX_HEIGHT,
  parameter int unsigned LANES      = SPC_LANES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // row_index[5:0], row_bits[69:6], point_x[85:70], point_y[101:86], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]      s_axis_tuser,
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // collide[0], boxes_overlap[1], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned OFS_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned LEN_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HLEN_W = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned EXT_W  = COORD_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOX,
    ST_ISECT,
    ST_SETUP,
    ST_ROWS,
    ST_DRAIN,
    ST_PREAD,
    ST_PWAIT,
    ST_RESULT
  } state_e;

  // configuration registers
  logic [COORD_W-1:0] a_left_q, a_top_q, b_left_q, b_top_q;
  logic [DIM_W-1:0]   a_width_q, a_height_q, b_width_q, b_height_q;

  // request fields
  logic                  s_fire;
  spc_mode_e             s_mode;
  logic [ROW_IDX_W-1:0]  s_row_index;
  logic [ROW_BITS_W-1:0] s_row_bits;
  logic [COORD_W-1:0]    s_point_x, s_point_y;
  logic                  row_ok;

  // control state
  state_e state_q, state_d;
  logic   rd_v_q, rd_v_d;
  logic   lane_v_q, lane_v_d;
  logic   out_v_q, out_v_d;

  // payload registers
  spc_mode_e          mode_q, mode_d;
  logic [COORD_W-1:0] px_q, px_d, py_q, py_d;
  logic [COORD_W-1:0] ax0_q, ax0_d, ay0_q, ay0_d, bx0_q, bx0_d, by0_q, by0_d;
  logic [EXT_W-1:0]   ax1_q, ax1_d, ay1_q, ay1_d, bx1_q, bx1_d, by1_q, by1_d;
  logic               ae_q, ae_d, be_q, be_d;
  logic [COORD_W-1:0] ix0_q, ix0_d, iy0_q, iy0_d;
  logic [EXT_W-1:0]   ix1_q, ix1_d, iy1_q, iy1_d;
  logic               ovl_q, ovl_d, coll_q, coll_d;
  logic [OFS_W-1:0]   sa_q, sa_d, sb_q, sb_d, c_q, c_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [ROW_W-1:0]   ra_q, ra_d, rb_q, rb_d, rows_left_q, rows_left_d;
  logic               out_coll_q, out_coll_d, out_ovl_q, out_ovl_d;

  // box and intersection helpers
  logic [LEN_W-1:0]  cw_a, cw_b;
  logic [HLEN_W-1:0] ch_a, ch_b;
  logic              box_hit, pt_in;

  // memories and lanes
  logic                 mem_we_a, mem_we_b, mem_re;
  logic [ROW_W-1:0]     mem_waddr;
  logic [MAX_WIDTH-1:0] rdata_a, rdata_b;
  logic [LANES-1:0]     lane_hit;
  logic                 merge_clr, merge_hit;

  assign s_fire      = s_axis_tvalid & s_axis_tready;
  assign s_mode      = spc_mode_e'(s_axis_tuser);
  assign s_row_index = s_axis_tdata[5:0];
  assign s_row_bits  = s_axis_tdata[69:6];
  assign s_point_x   = s_axis_tdata[85:70];
  assign s_point_y   = s_axis_tdata[101:86];

  assign row_ok    = {1'b0, s_row_index} < (ROW_IDX_W + 1)'(MAX_HEIGHT);
  assign mem_waddr = ROW_W'(s_row_index);
  assign mem_we_a  = s_fire && (s_mode == MODE_LOAD_A) && row_ok;
  assign mem_we_b  = s_fire && (s_mode == MODE_LOAD_B) && row_ok;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, out_ovl_q, out_coll_q};

  // saturate the window sizes
  always_comb begin
    cw_a = (a_width_q > DIM_W'(MAX_WIDTH)) ? LEN_W'(MAX_WIDTH) : LEN_W'(a_width_q);
    cw_b = (b_width_q > DIM_W'(MAX_WIDTH)) ? LEN_W'(MAX_WIDTH) : LEN_W'(b_width_q);
    ch_a = (a_height_q > DIM_W'(MAX_HEIGHT)) ? HLEN_W'(MAX_HEIGHT) : HLEN_W'(a_height_q);
    ch_b = (b_height_q > DIM_W'(MAX_HEIGHT)) ? HLEN_W'(MAX_HEIGHT) : HLEN_W'(b_height_q);
  end

  // box ends are 17 bits wide so they never wrap for a non-empty box
  assign box_hit = !ae_q && !be_q &&
                   !(EXT_W'(ax0_q) > bx1_q || ax1_q < EXT_W'(bx0_q) ||
                     EXT_W'(ay0_q) > by1_q || ay1_q < EXT_W'(by0_q));
  assign pt_in   = !ae_q && (px_q >= ax0_q) && (EXT_W'(px_q) <= ax1_q) &&
                   (py_q >= ay0_q) && (EXT_W'(py_q) <= ay1_q);

  always_comb begin
    state_d     = state_q;
    rd_v_d      = 1'b0;
    lane_v_d    = rd_v_q;
    out_v_d     = out_v_q;
    mode_d      = mode_q;
    px_d        = px_q;
    py_d        = py_q;
    ax0_d       = ax0_q;
    ay0_d       = ay0_q;
    bx0_d       = bx0_q;
    by0_d       = by0_q;
    ax1_d       = ax1_q;
    ay1_d       = ay1_q;
    bx1_d       = bx1_q;
    by1_d       = by1_q;
    ae_d        = ae_q;
    be_d        = be_q;
    ix0_d       = ix0_q;
    iy0_d       = iy0_q;
    ix1_d       = ix1_q;
    iy1_d       = iy1_q;
    ovl_d       = ovl_q;
    coll_d      = coll_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    c_d         = c_q;
    len_d       = len_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    rows_left_d = rows_left_q;
    out_coll_d  = out_coll_q;
    out_ovl_d   = out_ovl_q;
    mem_re      = 1'b0;
    merge_clr   = 1'b0;

    if (out_v_q && m_axis_tready) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && (s_mode == MODE_SPRITE || s_mode == MODE_POINT)) begin
          mode_d  = s_mode;
          px_d    = s_point_x;
          py_d    = s_point_y;
          state_d = ST_BOX;
        end
      end
      ST_BOX: begin
        ax0_d   = a_left_q;
        ay0_d   = a_top_q;
        bx0_d   = b_left_q;
        by0_d   = b_top_q;
        ax1_d   = EXT_W'(a_left_q) + EXT_W'(cw_a) - 1'b1;
        ay1_d   = EXT_W'(a_top_q) + EXT_W'(ch_a) - 1'b1;
        bx1_d   = EXT_W'(b_left_q) + EXT_W'(cw_b) - 1'b1;
        by1_d   = EXT_W'(b_top_q) + EXT_W'(ch_b) - 1'b1;
        ae_d    = (cw_a == '0) || (ch_a == '0);
        be_d    = (cw_b == '0) || (ch_b == '0);
        state_d = ST_ISECT;
      end
      ST_ISECT: begin
        coll_d = 1'b0;
        ix0_d  = (ax0_q > bx0_q) ? ax0_q : bx0_q;
        iy0_d  = (ay0_q > by0_q) ? ay0_q : by0_q;
        ix1_d  = (ax1_q < bx1_q) ? ax1_q : bx1_q;
        iy1_d  = (ay1_q < by1_q) ? ay1_q : by1_q;
        c_d    = OFS_W'(px_q - ax0_q);
        if (mode_q == MODE_SPRITE) begin
          ovl_d   = box_hit;
          state_d = box_hit ? ST_SETUP : ST_RESULT;
        end else begin
          ovl_d   = pt_in;
          ra_d    = ROW_W'(py_q - ay0_q);
          state_d = pt_in ? ST_PREAD : ST_RESULT;
        end
      end
      ST_SETUP: begin
        len_d       = LEN_W'(ix1_q - EXT_W'(ix0_q) + 1'b1);
        sa_d        = OFS_W'(ix0_q - ax0_q);
        sb_d        = OFS_W'(ix0_q - bx0_q);
        ra_d        = ROW_W'(iy0_q - ay0_q);
        rb_d        = ROW_W'(iy0_q - by0_q);
        rows_left_d = ROW_W'(iy1_q - EXT_W'(iy0_q));
        merge_clr   = 1'b1;
        state_d     = ST_ROWS;
      end
      ST_ROWS: begin
        mem_re = 1'b1;
        rd_v_d = 1'b1;
        if (rows_left_q == '0) begin
          state_d = ST_DRAIN;
        end else begin
          rows_left_d = rows_left_q - 1'b1;
          ra_d        = ra_q + 1'b1;
          rb_d        = rb_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // wait for the last row pair to pass the lanes and the merge
        if (!rd_v_q && !lane_v_q) begin
          coll_d  = merge_hit;
          state_d = ST_RESULT;
        end
      end
      ST_PREAD: begin
        mem_re  = 1'b1;
        state_d = ST_PWAIT;
      end
      ST_PWAIT: begin
        coll_d  = rdata_a[c_q];
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d    = 1'b1;
          out_coll_d = coll_q;
          out_ovl_d  = ovl_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_v_q   <= 1'b0;
      lane_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= rd_v_d;
      lane_v_q <= lane_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    px_q        <= px_d;
    py_q        <= py_d;
    ax0_q       <= ax0_d;
    ay0_q       <= ay0_d;
    bx0_q       <= bx0_d;
    by0_q       <= by0_d;
    ax1_q       <= ax1_d;
    ay1_q       <= ay1_d;
    bx1_q       <= bx1_d;
    by1_q       <= by1_d;
    ae_q        <= ae_d;
    be_q        <= be_d;
    ix0_q       <= ix0_d;
    iy0_q       <= iy0_d;
    ix1_q       <= ix1_d;
    iy1_q       <= iy1_d;
    ovl_q       <= ovl_d;
    coll_q      <= coll_d;
    sa_q        <= sa_d;
    sb_q        <= sb_d;
    c_q         <= c_d;
    len_q       <= len_d;
    ra_q        <= ra_d;
    rb_q        <= rb_d;
    rows_left_q <= rows_left_d;
    out_coll_q  <= out_coll_d;
    out_ovl_q   <= out_ovl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_left_q   <= '0;
      a_top_q    <= '0;
      a_width_q  <= DIM_W'(64);
      a_height_q <= DIM_W'(64);
      b_left_q   <= '0;
      b_top_q    <= '0;
      b_width_q  <= DIM_W'(64);
      b_height_q <= DIM_W'(64);
    end else if (cfg_we_i) begin
      unique case (spc_cfg_e'(cfg_addr_i))
        CFG_A_LEFT:   a_left_q   <= cfg_wdata_i;
        CFG_A_TOP:    a_top_q    <= cfg_wdata_i;
        CFG_A_WIDTH:  a_width_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_A_HEIGHT: a_height_q <= cfg_wdata_i[DIM_W-1:0];
        CFG_B_LEFT:   b_left_q   <= cfg_wdata_i;
        CFG_B_TOP:    b_top_q    <= cfg_wdata_i;
        CFG_B_WIDTH:  b_width_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_B_HEIGHT: b_height_q <= cfg_wdata_i[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  spc_mask_mem #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_mask_a (
    .clk_i   (clk_i),
    .we_i    (mem_we_a),
    .waddr_i (mem_waddr),
    .wdata_i (s_row_bits[MAX_WIDTH-1:0]),
    .re_i    (mem_re),
    .raddr_i (ra_q),
    .rdata_o (rdata_a)
  );

  spc_mask_mem #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_mask_b (
    .clk_i   (clk_i),
    .we_i    (mem_we_b),
    .waddr_i (mem_waddr),
    .wdata_i (s_row_bits[MAX_WIDTH-1:0]),
    .re_i    (mem_re),
    .raddr_i (rb_q),
    .rdata_o (rdata_b)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    spc_lane #(
      .MAX_WIDTH (MAX_WIDTH),
      .LANES     (LANES),
      .LANE_IDX  (l)
    ) u_lane (
      .clk_i (clk_i),
      .va_i  (rdata_a),
      .vb_i  (rdata_b),
      .sa_i  (sa_q),
      .sb_i  (sb_q),
      .len_i (len_q),
      .hit_o (lane_hit[l])
    );
  end

  spc_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (merge_clr),
    .vld_i      (lane_v_q),
    .lane_hit_i (lane_hit),
    .hit_o      (merge_hit)
  );

  `SPC_ASSERT_IMPL(a_collide_in_box, m_axis_tvalid, !m_axis_tdata[0] || m_axis_tdata[1], "collide reported without box overlap")
  `SPC_ASSERT_IMPL(a_result_drained, state_q == ST_RESULT, !rd_v_q && !lane_v_q, "result taken with rows still in flight")
  `SPC_ASSERT_IMPL(a_lane_in_sweep, lane_v_q, state_q == ST_ROWS || state_q == ST_DRAIN, "lane result outside a row sweep")
  `SPC_ASSERT_IMPL(a_no_rw_clash, mem_we_a || mem_we_b, !mem_re, "mask load during a mask read")
  `SPC_ASSERT_IMPL(a_result_source, $rose(m_axis_tvalid), $past(state_q == ST_RESULT), "result raised outside the result step")

endmodule
